>>> design/kst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and opcode constants for the keyed slot table.
// ----------------------------------------------------------------------------
package kst_pkg;

	localparam logic [2:0] OP_ADD     = 3'd0;
	localparam logic [2:0] OP_DISMISS = 3'd1;
	localparam logic [2:0] OP_EXPIRE  = 3'd2;
	localparam logic [2:0] OP_CLEAR   = 3'd3;
	localparam logic [2:0] OP_READ    = 3'd4;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [63:0] item_key;
		logic [31:0] payload_ref;
		logic [31:0] cur_tick;
		logic [31:0] ttl_ms;
		logic [2:0]  slot_index;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [2:0]  slot_used;
		logic        replaced_oldest;
		logic [3:0]  expired_count;
		logic [3:0]  active_count;
		logic [63:0] entry_key;
		logic [31:0] entry_payload;
		logic [31:0] entry_seq;
		logic [31:0] entry_created;
		logic [31:0] entry_ttl;
	} rsp_t;

	// One stored entry, excluding its valid bit
	typedef struct packed {
		logic [63:0] key;
		logic [31:0] payload;
		logic [31:0] seq;
		logic [31:0] created;
		logic [31:0] ttl;
	} entry_t;

endpackage

>>> design/kst_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_req_if / kst_rsp_if
// Valid/ready channels carrying requests and responses.
// ----------------------------------------------------------------------------
interface kst_req_if;
	logic          valid;
	logic          ready;
	kst_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface kst_rsp_if;
	logic          valid;
	logic          ready;
	kst_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> design/kst_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_mem
// Entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kst_mem #(
	parameter int SLOTS = 8,
	parameter int AW    = 3
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  kst_pkg::entry_t        wdata,
	input  logic [AW-1:0]          raddr,
	output kst_pkg::entry_t        rdata
);
	kst_pkg::entry_t mem_q [SLOTS];

	// Write, and read through an output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> design/keyed_slot_table_with_ttl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_table_with_ttl
// Keyed table of SLOTS entries with add, dismiss, expire, clear and read.
// ----------------------------------------------------------------------------
// One operation at a time. Add, dismiss and expire scan the entry memory one
// slot per cycle through its single read port; after the scan, add and
// dismiss pass through a write-back state before the response state, while
// expire goes straight to the response state, and clear, read and unknown
// opcodes pass through a single read state. The block returns to idle after
// each response transaction and takes the next request there, so each
// operation also waits out any response stall. Valid bits live in
// flip-flops, so there is no clearing pass after reset.
module keyed_slot_table_with_ttl #(
	parameter int SLOTS    = 8,
	parameter int KEY_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	kst_req_if.sink     req,
	kst_rsp_if.source   rsp
);
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_WRITE = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_RESP  = 3'd4;

	logic [2:0]        state_q;
	kst_pkg::req_t     req_q;
	logic [SLOTS-1:0]  valid_q;
	logic [31:0]       seq_q;
	logic [CW-1:0]     live_q;
	logic [CW-1:0]     cnt_q;      // scan issue counter (0..SLOTS)
	logic [AW-1:0]     addr_s1;    // slot whose data arrives this cycle
	logic              chk_s1;     // read data valid for the scan
	logic              hit_q;
	logic [AW-1:0]     hit_slot_q;
	logic [AW-1:0]     old_slot_q;
	logic [31:0]       old_seq_q;
	logic              old_any_q;
	logic [CW-1:0]     exp_q;
	kst_pkg::rsp_t     rsp_q;
	kst_pkg::rsp_t     rsp_next;

	logic              we;
	logic [AW-1:0]     waddr;
	kst_pkg::entry_t   wdata;
	logic [AW-1:0]     raddr;
	kst_pkg::entry_t   rdata;

	logic [63:0]       key_m;
	logic [31:0]       elapsed;
	logic              ent_valid;
	logic [AW-1:0]     free_slot;
	logic              free_any;
	logic [AW-1:0]     add_slot;

	kst_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign key_m     = req_q.item_key & ({64{1'b1}} >> (64 - KEY_BITS));
	assign elapsed   = req_q.cur_tick - rdata.created;
	assign ent_valid = valid_q[addr_s1];
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = (state_q == ST_RESP);
	assign rsp.data  = rsp_q;

	// Lowest free slot from the valid flops
	always_comb begin
		free_any  = 1'b0;
		free_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any  = 1'b1;
				free_slot = AW'(i);
			end
		end
	end

	always_comb begin
		if (hit_q) begin
			add_slot = hit_slot_q;
		end else if (free_any) begin
			add_slot = free_slot;
		end else begin
			add_slot = old_slot_q;
		end
	end

	// Memory read address and write-back
	always_comb begin
		raddr       = (state_q == ST_IDLE) ? AW'(req.data.slot_index) : cnt_q[AW-1:0];
		we          = (state_q == ST_WRITE) && (req_q.opcode == kst_pkg::OP_ADD);
		waddr       = add_slot;
		wdata.key     = key_m;
		wdata.payload = req_q.payload_ref;
		wdata.seq     = seq_q;
		wdata.created = req_q.cur_tick;
		wdata.ttl     = req_q.ttl_ms;
	end

	// Control: accept, scan, write back, respond
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			seq_q   <= '0;
			live_q  <= '0;
			cnt_q   <= '0;
			chk_s1  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						cnt_q  <= '0;
						chk_s1 <= 1'b0;
						case (req.data.opcode)
							kst_pkg::OP_ADD, kst_pkg::OP_DISMISS, kst_pkg::OP_EXPIRE:
								state_q <= ST_SCAN;
							kst_pkg::OP_CLEAR: begin
								valid_q <= '0;
								seq_q   <= '0;
								live_q  <= '0;
								state_q <= ST_READ;
							end
							default: state_q <= ST_READ;
						endcase
					end
				end
				ST_SCAN: begin
					// issue one read per cycle, check previous
					chk_s1 <= (cnt_q < CW'(SLOTS));
					if (cnt_q < CW'(SLOTS)) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (chk_s1 && req_q.opcode == kst_pkg::OP_EXPIRE && ent_valid
						&& rdata.ttl != 32'd0 && elapsed >= rdata.ttl) begin
						valid_q[addr_s1] <= 1'b0;
						live_q           <= live_q - CW'(1);
					end
					if (cnt_q == CW'(SLOTS) && !chk_s1) begin
						state_q <= (req_q.opcode == kst_pkg::OP_EXPIRE) ? ST_RESP : ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (req_q.opcode == kst_pkg::OP_ADD) begin
						seq_q            <= seq_q + 32'd1;
						valid_q[add_slot] <= 1'b1;
						if (!hit_q && free_any) begin
							live_q <= live_q + CW'(1);
						end
					end else if (hit_q) begin
						valid_q[hit_slot_q] <= 1'b0;
						live_q              <= live_q - CW'(1);
					end
					state_q <= ST_RESP;
				end
				ST_READ: state_q <= ST_RESP;
				ST_RESP: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Response contents; add and dismiss counts settle at write-back
	always_comb begin
		rsp_next = '0;
		rsp_next.active_count = 4'(live_q);
		case (req_q.opcode)
			kst_pkg::OP_ADD: begin
				rsp_next.slot_used       = 3'(add_slot);
				rsp_next.replaced_oldest = !hit_q && !free_any;
				rsp_next.active_count    = 4'(live_q + CW'(!hit_q && free_any));
			end
			kst_pkg::OP_DISMISS: begin
				rsp_next.status    = !hit_q;
				rsp_next.slot_used = hit_q ? 3'(hit_slot_q) : 3'd0;
				if (hit_q) begin
					rsp_next.active_count = 4'(live_q - CW'(1));
				end
			end
			kst_pkg::OP_EXPIRE: begin
				rsp_next.expired_count = 4'(exp_q);
			end
			kst_pkg::OP_READ: begin
				if (int'(req_q.slot_index) < SLOTS && valid_q[AW'(req_q.slot_index)]) begin
					rsp_next.entry_key     = rdata.key;
					rsp_next.entry_payload = rdata.payload;
					rsp_next.entry_seq     = rdata.seq;
					rsp_next.entry_created = rdata.created;
					rsp_next.entry_ttl     = rdata.ttl;
				end else begin
					rsp_next.status = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Datapath: scan bookkeeping and response register
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			req_q      <= req.data;
			hit_q      <= 1'b0;
			hit_slot_q <= '0;
			old_any_q  <= 1'b0;
			old_slot_q <= '0;
			old_seq_q  <= '0;
			exp_q      <= '0;
		end
		addr_s1 <= cnt_q[AW-1:0];
		if (state_q == ST_SCAN && chk_s1 && ent_valid) begin
			if (!hit_q && rdata.key == key_m) begin
				hit_q      <= 1'b1;
				hit_slot_q <= addr_s1;
			end
			if (!old_any_q || rdata.seq < old_seq_q) begin
				old_any_q  <= 1'b1;
				old_seq_q  <= rdata.seq;
				old_slot_q <= addr_s1;
			end
			if (rdata.ttl != 32'd0 && elapsed >= rdata.ttl) begin
				exp_q <= exp_q + CW'(1);
			end
		end
		// Capture the response in the state just before the response state
		if (state_q == ST_SCAN || state_q == ST_WRITE || state_q == ST_READ) begin
			rsp_q <= rsp_next;
		end
	end

`ifndef ASSERT_OFF
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CW'(SLOTS)) else $error("live count exceeds slots");
	a_live_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> CW'($countones(valid_q)) == live_q)
		else $error("live count out of step with valid bits");
	a_write_add: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q == ST_WRITE) else $error("memory write outside write-back");
`endif
endmodule

>>> tb/keyed_slot_table_with_ttl_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_table_with_ttl_tb
// Drives add, dismiss, expire, clear and read requests into the keyed slot
// table with random gaps and response stalls, predicts every response from a
// private copy of the table and compares each response field by field.
// ----------------------------------------------------------------------------
module keyed_slot_table_with_ttl_tb;

	localparam int NSLOT = 8;
	localparam int IDLE_LIMIT = 5000;

	// Table shadow with expected-response queue
	class slot_table_tracker;
		bit              live [NSLOT];
		kst_pkg::entry_t ent [NSLOT];
		logic [31:0]     seq_next;
		logic [3:0]      n_live;
		kst_pkg::rsp_t   pending [$];
		int              errors;

		function void wipe();
			for (int i = 0; i < NSLOT; i++) begin
				live[i] = 0;
				ent[i] = '0;
			end
			seq_next = 0;
			n_live = 0;
		endfunction

		function void note_request(kst_pkg::req_t r);
			kst_pkg::rsp_t o;
			int   s;
			o = '0;
			s = -1;
			case (r.opcode)
				kst_pkg::OP_ADD: begin
					for (int i = 0; i < NSLOT; i++)
						if (s < 0 && live[i] && ent[i].key == r.item_key) s = i;
					if (s < 0) begin
						for (int i = 0; i < NSLOT; i++)
							if (s < 0 && !live[i]) s = i;
						if (s >= 0) n_live++;
						else begin
							s = 0;
							for (int i = 1; i < NSLOT; i++)
								if (ent[i].seq < ent[s].seq) s = i;
							o.replaced_oldest = 1;
						end
					end
					live[s] = 1;
					ent[s] = '{r.item_key, r.payload_ref, seq_next, r.cur_tick, r.ttl_ms};
					seq_next++;
					o.slot_used = s[2:0];
				end
				kst_pkg::OP_DISMISS: begin
					for (int i = 0; i < NSLOT; i++)
						if (s < 0 && live[i] && ent[i].key == r.item_key) s = i;
					if (s < 0) o.status = 1;
					else begin
						live[s] = 0;
						ent[s] = '0;
						n_live--;
						o.slot_used = s[2:0];
					end
				end
				kst_pkg::OP_EXPIRE: begin
					for (int i = 0; i < NSLOT; i++)
						if (live[i] && ent[i].ttl != 0 &&
						    (r.cur_tick - ent[i].created) >= ent[i].ttl) begin
							live[i] = 0;
							ent[i] = '0;
							n_live--;
							o.expired_count++;
						end
				end
				kst_pkg::OP_CLEAR: wipe();
				kst_pkg::OP_READ: begin
					if (live[r.slot_index]) begin
						o.entry_key     = ent[r.slot_index].key;
						o.entry_payload = ent[r.slot_index].payload;
						o.entry_seq     = ent[r.slot_index].seq;
						o.entry_created = ent[r.slot_index].created;
						o.entry_ttl     = ent[r.slot_index].ttl;
					end else o.status = 1;
				end
				default: ;
			endcase
			o.active_count = n_live;
			pending.push_back(o);
		endfunction

		function void check_response(kst_pkg::rsp_t a);
			kst_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$error("response with none expected: %p", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$error("status exp %0h got %0h", e.status, a.status); errors++;
			end
			if (a.slot_used !== e.slot_used) begin
				$error("slot_used exp %0h got %0h", e.slot_used, a.slot_used); errors++;
			end
			if (a.replaced_oldest !== e.replaced_oldest) begin
				$error("replaced_oldest exp %0h got %0h", e.replaced_oldest,
					a.replaced_oldest); errors++;
			end
			if (a.expired_count !== e.expired_count) begin
				$error("expired_count exp %0h got %0h", e.expired_count,
					a.expired_count); errors++;
			end
			if (a.active_count !== e.active_count) begin
				$error("active_count exp %0h got %0h", e.active_count, a.active_count);
				errors++;
			end
			if (a.entry_key !== e.entry_key) begin
				$error("entry_key exp %0h got %0h", e.entry_key, a.entry_key); errors++;
			end
			if (a.entry_payload !== e.entry_payload) begin
				$error("entry_payload exp %0h got %0h", e.entry_payload,
					a.entry_payload); errors++;
			end
			if (a.entry_seq !== e.entry_seq) begin
				$error("entry_seq exp %0h got %0h", e.entry_seq, a.entry_seq); errors++;
			end
			if (a.entry_created !== e.entry_created) begin
				$error("entry_created exp %0h got %0h", e.entry_created,
					a.entry_created); errors++;
			end
			if (a.entry_ttl !== e.entry_ttl) begin
				$error("entry_ttl exp %0h got %0h", e.entry_ttl, a.entry_ttl); errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	kst_req_if req ();
	kst_rsp_if rsp ();

	keyed_slot_table_with_ttl uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	slot_table_tracker table_model;
	int          idle_cycles = 0;
	logic [63:0] key_pool [8];
	logic [31:0] tick;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Count cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Check responses; stall with random gaps
	initial begin
		int stall;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				table_model.check_response(rsp.data);
				stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
				if (stall > 0) rsp.ready <= 1'b0;
			end else if (!rsp.ready) begin
				if (stall > 0) stall--;
				if (stall == 0) rsp.ready <= 1'b1;
			end
		end
	end

	// Hold valid across back-to-back requests; drop it only for a gap
	task automatic send_request(kst_pkg::req_t r, int gap);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= r;
		do @(posedge clk); while (!req.ready);
		table_model.note_request(r);
	endtask

	function automatic kst_pkg::req_t make_request(logic [2:0] op, logic [63:0] k,
		logic [31:0] ttl, logic [2:0] idx);
		kst_pkg::req_t r;
		r.opcode      = op;
		r.item_key    = k;
		r.payload_ref = $urandom();
		r.cur_tick    = tick;
		r.ttl_ms      = ttl;
		r.slot_index  = idx;
		return r;
	endfunction

	function automatic logic [31:0] rand_ttl();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom();
			default: return $urandom_range(1, 200);
		endcase
	endfunction

	function automatic int rand_gap();
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
	endfunction

	initial begin
		kst_pkg::req_t r;
		logic [63:0]   k;
		table_model = new();
		table_model.wipe();
		table_model.errors = 0;
		tick = 0;
		req.valid = 1'b0;
		req.data  = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty reads, misses, fill, update, eviction, expiry, wrap
		send_request(make_request(kst_pkg::OP_READ, 0, 0, 3'd7), 0);
		send_request(make_request(kst_pkg::OP_DISMISS, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0), 0);
		send_request(make_request(kst_pkg::OP_EXPIRE, 0, 0, 0), 0);
		for (int i = 0; i < 8; i++) begin
			tick = 32'hFFFF_FFF0 + i;
			k = (i == 0) ? 64'h0 : (i == 7) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom(), $urandom()};
			key_pool[i] = k;
			send_request(make_request(kst_pkg::OP_ADD, k, (i < 2) ? 32'd0 : 32'd20 + i,
				3'(i)), 0);
		end
		send_request(make_request(kst_pkg::OP_ADD, key_pool[3], 32'hFFFF_FFFF, 0), 0);
		send_request(make_request(kst_pkg::OP_ADD, 64'h1234_5678_9ABC_DEF0, 32'd5, 0), 0);
		send_request(make_request(kst_pkg::OP_READ, 0, 0, 3'd0), 1);
		send_request(make_request(kst_pkg::OP_READ, 0, 0, 3'd3), 0);
		send_request(make_request(kst_pkg::OP_DISMISS, key_pool[7], 0, 0), 0);
		tick = 32'd30;
		send_request(make_request(kst_pkg::OP_EXPIRE, 0, 0, 0), 0);
		send_request(make_request(kst_pkg::OP_READ, 0, 0, 3'd5), 0);
		send_request(make_request(3'd5, 0, 0, 0), 0);
		send_request(make_request(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 0, 3'd7), 0);
		send_request(make_request(kst_pkg::OP_CLEAR, 0, 0, 0), 0);
		send_request(make_request(kst_pkg::OP_READ, 0, 0, 3'd1), 0);

		// Random: keys mostly from a small pool so hits, evictions and expiry recur
		for (int n = 0; n < 1700; n++) begin
			int sel;
			if ($urandom_range(0, 15) == 0) key_pool[$urandom_range(0, 7)] = {$urandom(), $urandom()};
			k = ($urandom_range(0, 9) == 0) ? {$urandom(), $urandom()} : key_pool[$urandom_range(0, 7)];
			tick = ($urandom_range(0, 49) == 0) ? $urandom() : tick + $urandom_range(0, 40);
			sel = $urandom_range(0, 99);
			if (sel < 45) r = make_request(kst_pkg::OP_ADD, k, rand_ttl(), 0);
			else if (sel < 60) r = make_request(kst_pkg::OP_DISMISS, k, 0, 0);
			else if (sel < 72) r = make_request(kst_pkg::OP_EXPIRE, 0, 0, 0);
			else if (sel < 74) r = make_request(kst_pkg::OP_CLEAR, 0, 0, 0);
			else if (sel < 97) r = make_request(kst_pkg::OP_READ, 0, 0, 3'($urandom_range(0, 7)));
			else r = make_request(3'($urandom_range(5, 7)), k, $urandom(), 3'($urandom()));
			r.payload_ref = $urandom();
			send_request(r, rand_gap());
		end
		req.valid <= 1'b0;

		// Drain
		while (table_model.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (table_model.errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule

>>> sim.f
design/kst_pkg.sv
design/kst_if.sv
design/kst_mem.sv
design/keyed_slot_table_with_ttl.sv
tb/keyed_slot_table_with_ttl_tb.sv
